[src/water_flow_leak_monitor_macros.svh]
// assertion macros for the flow monitor checker
`ifndef WATER_FLOW_LEAK_MONITOR_MACROS_SVH
`define WATER_FLOW_LEAK_MONITOR_MACROS_SVH
// implication checked on every edge outside reset
`define WFLM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%s failed", "label");
// next-cycle implication checked outside reset
`define WFLM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%s failed", "label");
`endif

[src/wflm_pkg.sv]
// package: types, constants and codes of the flow monitor
`default_nettype none
package wflm_pkg;
  localparam int HistDepth = 32;
  localparam int HistAw = $clog2(HistDepth);
  localparam int HistCw = $clog2(HistDepth + 1);

  localparam logic [2:0] OP_PULSE = 3'd0;
  localparam logic [2:0] OP_TICK = 3'd1;
  localparam logic [2:0] OP_CMD = 3'd2;
  localparam logic [2:0] OP_TIMEOUT = 3'd3;
  localparam logic [2:0] OP_READ = 3'd4;

  localparam logic [7:0] CMD_ACK = 8'h10;
  localparam logic [7:0] CMD_STATUS = 8'h11;
  localparam logic [7:0] CMD_OPEN = 8'h12;
  localparam logic [7:0] CMD_CLOSE = 8'h13;
  localparam logic [7:0] CMD_ARM = 8'h14;
  localparam logic [7:0] CMD_DISARM = 8'h15;
  localparam logic [7:0] CMD_INTERVAL = 8'h16;
  localparam logic [7:0] CMD_CLEAR = 8'h17;

  localparam logic [7:0] F_LEAK = 8'h01;
  localparam logic [7:0] F_BIG = 8'h02;
  localparam logic [7:0] F_FAULT = 8'h04;
  localparam logic [7:0] F_OVER = 8'h08;
  localparam logic [7:0] F_TIMEOUT = 8'h10;
  localparam logic [7:0] F_BADCMD = 8'h20;
  localparam logic [7:0] F_FULL = 8'h80;
  localparam logic [7:0] F_MASK = 8'hBF;

  localparam logic [2:0] V_IDLE = 3'd0;
  localparam logic [2:0] V_OPEN = 3'd1;
  localparam logic [2:0] V_REQ = 3'd2;
  localparam logic [2:0] V_CLOSED = 3'd3;
  localparam logic [2:0] V_FAULT = 3'd4;

  localparam logic [2:0] REG_PPG = 3'd0;
  localparam logic [2:0] REG_LEAK_TH = 3'd1;
  localparam logic [2:0] REG_LEAK_SUS = 3'd2;
  localparam logic [2:0] REG_BIG_TH = 3'd3;
  localparam logic [2:0] REG_SETTLE = 3'd4;
  localparam logic [2:0] REG_FAULT_MIN = 3'd5;
  localparam logic [2:0] REG_TICKS = 3'd6;

  // quotient bits needed: dividend is at most 655350 + 32767 < 2^20
  localparam int DivNw = 20;
  localparam int DivCw = $clog2(DivNw + 1);

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] cmd_code;
    logic [7:0] cmd_arg;
    logic [7:0] cmd_check;
    logic [4:0] history_index;
  } in_beat_t;

  typedef struct packed {
    logic       minute_done;
    logic [7:0] minute_flow;
    logic [7:0] flag_bits;
    logic [2:0] valve_mode;
    logic       valve_drive;
    logic [1:0] wake_request;
    logic [5:0] history_count;
    logic [4:0] history_head;
    logic [7:0] history_value;
    logic       command_ok;
    logic       armed_now;
  } out_beat_t;

  typedef struct packed {
    logic              start;
    logic [DivNw-1:0]  dividend;
    logic [15:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic       busy;
    logic [7:0] flow;
    logic       over;
  } div_rsp_t;
endpackage
`default_nettype wire

[src/wflm_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module wflm_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

[src/wflm_div.sv]
// shift-subtract divider, one quotient bit a cycle, saturating to 8 bits
`default_nettype none
module wflm_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire wflm_pkg::div_req_t  req,
  output wflm_pkg::div_rsp_t       rsp
);
  import wflm_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DivCw-1:0] cnt_r, cnt_nxt;
  logic [DivNw-1:0] num_r, num_nxt;
  logic [DivNw-1:0] quo_r, quo_nxt;
  logic [16:0]      rem_r, rem_nxt;
  logic [15:0]      den_r, den_nxt;
  logic [16:0]      trial;
  logic [16:0]      diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    num_nxt = num_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    trial = {rem_r[15:0], num_r[DivNw-1]};
    diff = trial - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt = DivCw'(DivNw);
      num_nxt = req.dividend;
      quo_nxt = '0;
      rem_nxt = '0;
      den_nxt = req.divisor;
    end else if (busy_r) begin
      num_nxt = {num_r[DivNw-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff;
        quo_nxt = {quo_r[DivNw-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DivNw-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DivCw'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  // zero divisor gives all-ones quotient, which saturates as required
  always_comb begin
    rsp.done = done_r;
    rsp.busy = busy_r;
    rsp.over = (quo_r > DivNw'(255));
    rsp.flow = rsp.over ? 8'hFF : quo_r[7:0];
  end
endmodule
`default_nettype wire

[src/water_flow_leak_monitor.sv]
// top level: flow monitor sequencer, divider and shared history ram
// pulse, command, timeout and non-closing tick beats go through S_EXEC and S_OUT
// to the result register; history reads also pass S_RDWT (ram read is registered)
// a minute-closing tick passes S_EXEC, S_DIV for the 20-step serial divider, S_CHECK and S_OUT
// one beat in flight at a time; in_ready low until its result is taken
// rst_n synchronous active low: registers to their defaults, valve idle,
// shutoff armed, report interval 32; history ram contents are not cleared
`default_nettype none
module water_flow_leak_monitor (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wflm_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wflm_pkg::out_beat_t       out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [15:0]          cfg_wdata
);
  import wflm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_RDWT  = 6'b000100,
    S_DIV   = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] ppg_r;
  logic [7:0]  leak_th_r, leak_sus_r, big_th_r, settle_min_r, fault_min_r, ticks_r;

  // block state
  logic [15:0]     pulses_r, pulses_nxt;
  logic [7:0]      tick_r, tick_nxt;
  logic [7:0]      flow_r, flow_nxt;
  logic [HistAw-1:0] head_r, head_nxt;
  logic [HistCw-1:0] count_r, count_nxt;
  logic [7:0]      ev_r, ev_nxt;
  logic [7:0]      leak_run_r, leak_run_nxt;
  logic [2:0]      valve_r, valve_nxt;
  logic            armed_r, armed_nxt;
  logic [HistCw-1:0] interval_r, interval_nxt;
  logic [7:0]      settle_r, settle_nxt;
  logic [7:0]      cfrun_r, cfrun_nxt;

  // per-beat holding
  in_beat_t        beat_r, beat_nxt;
  out_beat_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            done_nxt_b;
  logic [1:0]      wake_v;
  logic            ok_v;
  logic            hit_r, hit_nxt;

  // divider and shared history ram
  div_req_t        dreq;
  div_rsp_t        drsp;
  logic            ram_we;
  logic [HistAw-1:0] ram_addr;
  logic [7:0]      ram_wdata, ram_rdata;

  wflm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  wflm_ram #(.Width(8), .Depth(HistDepth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // config writes, taken any time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppg_r <= 16'd450;
      leak_th_r <= 8'd1;
      leak_sus_r <= 8'd10;
      big_th_r <= 8'd80;
      settle_min_r <= 8'd1;
      fault_min_r <= 8'd3;
      ticks_r <= 8'd60;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PPG:       ppg_r <= cfg_wdata;
        REG_LEAK_TH:   leak_th_r <= cfg_wdata[7:0];
        REG_LEAK_SUS:  leak_sus_r <= cfg_wdata[7:0];
        REG_BIG_TH:    big_th_r <= cfg_wdata[7:0];
        REG_SETTLE:    settle_min_r <= cfg_wdata[7:0];
        REG_FAULT_MIN: fault_min_r <= cfg_wdata[7:0];
        REG_TICKS:     ticks_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;

  // dividend = pulses*10 + ppg/2, both fit well under 2^20
  logic [DivNw-1:0] dividend;
  logic [7:0]       tick_inc;
  logic [7:0]       m;
  logic [7:0]       lr, cr, sc;
  logic             evf;
  logic             cmd_good;
  logic [HistAw-1:0] rd_pos;

  assign dividend = DivNw'({pulses_r, 3'b000}) + DivNw'({pulses_r, 1'b0})
                  + DivNw'(ppg_r[15:1]);
  assign tick_inc = tick_r + 8'd1;
  // chronological index to ring position, wraps modulo the depth
  assign rd_pos = head_r - count_r[HistAw-1:0] + beat_r.history_index[HistAw-1:0];

  always_comb begin
    state_nxt = state_r;
    pulses_nxt = pulses_r;
    tick_nxt = tick_r;
    flow_nxt = flow_r;
    head_nxt = head_r;
    count_nxt = count_r;
    ev_nxt = ev_r;
    leak_run_nxt = leak_run_r;
    valve_nxt = valve_r;
    armed_nxt = armed_r;
    interval_nxt = interval_r;
    settle_nxt = settle_r;
    cfrun_nxt = cfrun_r;
    beat_nxt = beat_r;
    hit_nxt = hit_r;
    out_valid_nxt = out_valid_r;
    res_nxt = res_r;
    done_nxt_b = 1'b0;
    wake_v = 2'd0;
    ok_v = 1'b0;
    dreq = '0;
    ram_we = 1'b0;
    ram_addr = rd_pos;
    ram_wdata = drsp.flow;
    m = drsp.flow;
    lr = leak_run_r;
    cr = cfrun_r;
    sc = settle_r;
    evf = 1'b0;
    cmd_good = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          beat_nxt = in_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        case (beat_r.opcode)
          OP_PULSE: begin
            if (pulses_r != 16'hFFFF) pulses_nxt = pulses_r + 16'd1;
          end
          OP_TICK: begin
            if (tick_inc >= ticks_r) begin
              tick_nxt = '0;
              dreq.start = 1'b1;
              dreq.dividend = dividend;
              dreq.divisor = ppg_r;
              state_nxt = S_DIV;
            end else begin
              tick_nxt = tick_inc;
            end
          end
          OP_CMD: begin
            if (beat_r.cmd_code == CMD_INTERVAL) begin
              if (beat_r.cmd_check != (beat_r.cmd_code ^ beat_r.cmd_arg)) begin
                ev_nxt = ev_r | F_BADCMD;
              end else if (beat_r.cmd_arg != 8'd0 &&
                           beat_r.cmd_arg <= 8'(HistDepth)) begin
                interval_nxt = HistCw'(beat_r.cmd_arg);
                ok_v = 1'b1;
              end else begin
                ev_nxt = ev_r | F_BADCMD;
              end
            end else begin
              cmd_good = beat_r.cmd_code >= CMD_ACK && beat_r.cmd_code <= CMD_CLEAR
                         && beat_r.cmd_check == beat_r.cmd_code;
              if (!cmd_good) begin
                ev_nxt = ev_r | F_BADCMD;
              end else begin
                ok_v = 1'b1;
                unique case (beat_r.cmd_code)
                  CMD_ACK: begin
                    head_nxt = '0;
                    count_nxt = '0;
                    ev_nxt = ev_r & ~F_FULL;
                  end
                  CMD_OPEN:   if (valve_r != V_FAULT) valve_nxt = V_OPEN;
                  CMD_CLOSE:  if (valve_r != V_CLOSED && valve_r != V_FAULT)
                                valve_nxt = V_REQ;
                  CMD_ARM:    armed_nxt = 1'b1;
                  CMD_DISARM: armed_nxt = 1'b0;
                  CMD_CLEAR: begin
                    ev_nxt = '0;
                    if (valve_r == V_FAULT) valve_nxt = V_IDLE;
                  end
                  default: ;
                endcase
              end
            end
          end
          OP_TIMEOUT: ev_nxt = ev_r | F_TIMEOUT;
          OP_READ: begin
            hit_nxt = HistCw'(beat_r.history_index) < count_r;
            state_nxt = S_RDWT;
          end
          default: ;
        endcase
        res_nxt.command_ok = ok_v;
        res_nxt.minute_done = 1'b0;
        res_nxt.wake_request = 2'd0;
        res_nxt.history_value = '0;
      end
      S_RDWT: begin
        // ram output valid now
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (drsp.done) begin
          // store the minute and update flags
          ram_we = 1'b1;
          ram_addr = head_r;
          head_nxt = head_r + 1'b1;
          if (count_r < HistCw'(HistDepth)) count_nxt = count_r + 1'b1;
          flow_nxt = m;
          pulses_nxt = '0;
          ev_nxt = ev_r | (drsp.over ? F_OVER : 8'h00);
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        m = flow_r;
        ev_nxt = ev_r;
        if (m >= big_th_r) begin
          ev_nxt = ev_nxt | F_BIG;
          evf = 1'b1;
        end
        if (m >= leak_th_r && m < big_th_r) begin
          lr = (leak_run_r != 8'hFF) ? leak_run_r + 8'd1 : leak_run_r;
          if (lr >= leak_sus_r) begin
            ev_nxt = ev_nxt | F_LEAK;
            evf = 1'b1;
          end
        end else if (m < leak_th_r) begin
          lr = '0;
        end
        leak_run_nxt = lr;
        valve_nxt = valve_r;
        if (armed_r && (ev_nxt & (F_LEAK | F_BIG)) != 8'h00 &&
            valve_r != V_CLOSED && valve_r != V_FAULT) begin
          valve_nxt = V_REQ;
        end
        if (valve_nxt == V_CLOSED) begin
          if (m >= leak_th_r) begin
            cr = (cfrun_r != 8'hFF) ? cfrun_r + 8'd1 : cfrun_r;
            if (cr >= fault_min_r) begin
              valve_nxt = V_FAULT;
              ev_nxt = ev_nxt | F_FAULT;
              evf = 1'b1;
            end
          end else begin
            cr = '0;
          end
        end
        if (count_r >= interval_r) ev_nxt = ev_nxt | F_FULL;
        if ((ev_nxt & F_FULL) != 8'h00) wake_v = 2'd1;
        else if (evf) wake_v = 2'd2;
        if (valve_nxt == V_REQ) begin
          sc = (settle_r != 8'hFF) ? settle_r + 8'd1 : settle_r;
          if (sc >= settle_min_r) begin
            valve_nxt = V_CLOSED;
            cr = '0;
          end
        end else begin
          sc = '0;
        end
        cfrun_nxt = cr;
        settle_nxt = sc;
        done_nxt_b = 1'b1;
        res_nxt.minute_done = done_nxt_b;
        res_nxt.wake_request = wake_v;
        res_nxt.command_ok = 1'b0;
        res_nxt.history_value = '0;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // status fields from state as it now stands
        res_nxt.minute_flow = flow_r;
        res_nxt.flag_bits = ev_r & F_MASK;
        res_nxt.valve_mode = valve_r;
        res_nxt.valve_drive = valve_r == V_REQ || valve_r == V_CLOSED || valve_r == V_FAULT;
        res_nxt.history_count = 6'(count_r);
        res_nxt.history_head = 5'(head_r);
        res_nxt.armed_now = armed_r;
        if (beat_r.opcode == OP_READ) res_nxt.history_value = hit_r ? ram_rdata : 8'h00;
        out_valid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pulses_r <= '0;
      tick_r <= '0;
      flow_r <= '0;
      head_r <= '0;
      count_r <= '0;
      ev_r <= '0;
      leak_run_r <= '0;
      valve_r <= V_IDLE;
      armed_r <= 1'b1;
      interval_r <= HistCw'(HistDepth);
      settle_r <= '0;
      cfrun_r <= '0;
      out_valid_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pulses_r <= pulses_nxt;
      tick_r <= tick_nxt;
      flow_r <= flow_nxt;
      head_r <= head_nxt;
      count_r <= count_nxt;
      ev_r <= ev_nxt;
      leak_run_r <= leak_run_nxt;
      valve_r <= valve_nxt;
      armed_r <= armed_nxt;
      interval_r <= interval_nxt;
      settle_r <= settle_nxt;
      cfrun_r <= cfrun_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r <= hit_nxt;
    end
    beat_r <= beat_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = res_r;
endmodule
`default_nettype wire

[src/wflm_checker.sv]
// port-level checker for the flow monitor, bound to the top level
`default_nettype none
`include "water_flow_leak_monitor_macros.svh"
module wflm_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire wflm_pkg::out_beat_t out_data
);
  import wflm_pkg::*;

  `WFLM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `WFLM_ASSERT_IMP(a_no_accept_while_out, clk, rst_n, out_valid, !in_ready)
  `WFLM_ASSERT_IMP(a_drive_mode, clk, rst_n, out_valid, out_data.valve_drive == (out_data.valve_mode == V_REQ || out_data.valve_mode == V_CLOSED || out_data.valve_mode == V_FAULT))
  `WFLM_ASSERT_IMP(a_wake_only_minute, clk, rst_n, out_valid && !out_data.minute_done, out_data.wake_request == 2'd0)
  `WFLM_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind water_flow_leak_monitor wflm_checker u_wflm_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
